### rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define ASSERT_HOLDS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

### rtl/crt_pkg.sv
`timescale 1ns / 1ps

package crt_pkg;

	localparam int DEF_MAX_CHUNKS = 1024;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TOTAL_BYTES      = 2'd0,
		CFG_CHUNK_BYTES      = 2'd1,
		CFG_NUMBER_OF_CHUNKS = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_NOT_SET_UP  = 3'd1,
		ST_INDEX_RANGE = 3'd2,
		ST_COMPLETE    = 3'd3,
		ST_DUPLICATE   = 3'd4,
		ST_NO_PAYLOAD  = 3'd5,
		ST_LENGTH      = 3'd6
	} status_t;

	typedef struct packed {
		logic [9:0]  chunk_number;
		logic [23:0] chunk_length;
		logic        payload_present;
	} chunk_item_t;

	typedef struct packed {
		status_t     status;
		logic [25:0] write_offset;
		logic [10:0] received_total;
		logic        transfer_complete;
	} result_item_t;

	typedef struct packed {
		logic rd;
		logic wr;
		logic clr;
	} map_ctl_t;

endpackage

### rtl/crt_bitmap.sv
`timescale 1ns / 1ps

module crt_bitmap
	import crt_pkg::*;
#(
	parameter int ROW_W  = 32,
	parameter int ROWS   = 32,
	parameter int ROW_AW = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  map_ctl_t          ctl,
	input  logic [ROW_AW-1:0] rd_row,
	input  logic [ROW_AW-1:0] wr_row,
	input  logic [ROW_W-1:0]  wr_bits,
	output logic [ROW_W-1:0]  rd_bits
);

	logic [ROW_W-1:0] mem_q [ROWS];
	logic [ROWS-1:0]  row_vld_q;
	logic [ROW_W-1:0] rd_data_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem_q[wr_row] <= wr_bits;
		end
		if (ctl.rd) begin
			rd_data_q <= mem_q[rd_row];
		end
	end

	// A row that has not been written since the last clear reads as all zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (ctl.clr) begin
				row_vld_q <= '0;
			end else if (ctl.wr) begin
				row_vld_q[wr_row] <= 1'b1;
			end
			if (ctl.rd) begin
				rd_vld_q <= row_vld_q[rd_row];
			end
		end
	end

	assign rd_bits = rd_vld_q ? rd_data_q : '0;

endmodule

### rtl/chunk_reassembly_tracker_unit.sv
`timescale 1ns / 1ps

// Chunk reassembly tracker. Each accepted chunk header takes two steps: in the first the
// row of the received bitmap that holds its bit is read from the bitmap memory, and in the
// second the checks run, the row is written back and the result is loaded into the output
// register, so no new header is taken until the last has left its check step. A header waits
// there for as long as an earlier result is still held by a stall on the result side. The
// bitmap rows carry flip-flop valid bits, so reset and configuration writes clear the tracker
// at once, with no clearing pass. Configuration writes are taken whenever no header is in its
// check step; a write to a defined index clears the bitmap, the count and the complete flag.
module chunk_reassembly_tracker_unit
	import crt_pkg::*;
#(
	parameter int MAX_CHUNKS = DEF_MAX_CHUNKS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  chunk_valid,
	output logic                  chunk_stall,
	input  chunk_item_t           chunk,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_item_t          result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int ROW_W  = (MAX_CHUNKS > 8192) ? 256 : 32;
	localparam int ROWS   = (MAX_CHUNKS + ROW_W - 1) / ROW_W;
	localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int BIT_AW = $clog2(ROW_W);

	logic [23:0]       total_q;
	logic [15:0]       chunk_bytes_q;
	logic [10:0]       num_chunks_q;
	logic [10:0]       count_q;
	logic              done_q;

	logic              valid_s1;
	chunk_item_t       item_s1;
	logic [25:0]       off_s1;
	logic [ROW_AW-1:0] row_s1;
	logic [BIT_AW-1:0] bit_s1;

	logic              result_valid_q;
	result_item_t      result_q;

	logic              chunk_acc;
	logic              cfg_acc;
	logic              cfg_hit;
	logic              fire;
	map_ctl_t          map_ctl;
	logic [ROW_AW-1:0] rd_row;
	logic [ROW_W-1:0]  row_bits;
	logic [ROW_W-1:0]  row_next;

	status_t           status;
	logic [10:0]       idx_ext;
	logic              last_chunk;
	logic [23:0]       expected;
	logic [10:0]       count_next;
	result_item_t      res;

	assign chunk_stall = valid_s1 || cfg_valid;
	assign chunk_acc   = chunk_valid && !chunk_stall;
	assign cfg_ready   = !valid_s1;
	assign cfg_acc     = cfg_valid && cfg_ready;
	assign fire        = valid_s1 && (!result_valid_q || !result_stall);

	always_comb begin
		case (cfg_idx_t'(cfg_index))
			CFG_TOTAL_BYTES:      cfg_hit = 1'b1;
			CFG_CHUNK_BYTES:      cfg_hit = 1'b1;
			CFG_NUMBER_OF_CHUNKS: cfg_hit = 1'b1;
			default:              cfg_hit = 1'b0;
		endcase
	end

	assign rd_row = ROW_AW'(32'(chunk.chunk_number) >> BIT_AW);

	always_comb begin
		map_ctl.rd  = chunk_acc;
		map_ctl.wr  = fire && (status == ST_OK);
		map_ctl.clr = cfg_acc && cfg_hit;
	end

	crt_bitmap #(
		.ROW_W  (ROW_W),
		.ROWS   (ROWS),
		.ROW_AW (ROW_AW)
	) u_bitmap (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (map_ctl),
		.rd_row  (rd_row),
		.wr_row  (row_s1),
		.wr_bits (row_next),
		.rd_bits (row_bits)
	);

	always_comb begin
		idx_ext    = {1'b0, item_s1.chunk_number};
		last_chunk = (idx_ext + 11'd1) == num_chunks_q;
		expected   = last_chunk ? (total_q - off_s1[23:0]) : {8'd0, chunk_bytes_q};
		count_next = count_q + 11'd1;
		row_next   = row_bits | (ROW_W'(1) << bit_s1);

		if (num_chunks_q == 11'd0) begin
			status = ST_NOT_SET_UP;
		end else if (idx_ext >= num_chunks_q
				|| 32'(item_s1.chunk_number) >= 32'(MAX_CHUNKS)) begin
			status = ST_INDEX_RANGE;
		end else if (done_q) begin
			status = ST_COMPLETE;
		end else if (row_bits[bit_s1]) begin
			status = ST_DUPLICATE;
		end else if (item_s1.chunk_length != 24'd0 && !item_s1.payload_present) begin
			status = ST_NO_PAYLOAD;
		end else if (item_s1.chunk_length != expected) begin
			status = ST_LENGTH;
		end else begin
			status = ST_OK;
		end

		res.status = status;
		if (status == ST_OK) begin
			res.write_offset      = off_s1;
			res.received_total    = count_next;
			res.transfer_complete = (count_next == num_chunks_q);
		end else begin
			res.write_offset      = '0;
			res.received_total    = count_q;
			res.transfer_complete = done_q;
		end
	end

	always_ff @(posedge clk) begin
		if (chunk_acc) begin
			item_s1 <= chunk;
			off_s1  <= 26'(chunk.chunk_number) * 26'(chunk_bytes_q);
			row_s1  <= rd_row;
			bit_s1  <= chunk.chunk_number[BIT_AW-1:0];
		end
		if (fire) begin
			result_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q        <= '0;
			chunk_bytes_q  <= '0;
			num_chunks_q   <= '0;
			count_q        <= '0;
			done_q         <= 1'b0;
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_acc) begin
				case (cfg_idx_t'(cfg_index))
					CFG_TOTAL_BYTES:      total_q       <= cfg_data;
					CFG_CHUNK_BYTES:      chunk_bytes_q <= cfg_data[15:0];
					CFG_NUMBER_OF_CHUNKS: num_chunks_q  <= cfg_data[10:0];
					default:              ;
				endcase
				if (cfg_hit) begin
					count_q <= '0;
					done_q  <= 1'b0;
				end
			end else if (fire && status == ST_OK) begin
				count_q <= count_next;
				done_q  <= res.transfer_complete;
			end

			if (chunk_acc) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end

			if (fire) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

### rtl/crt_checker.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module crt_checker
	import crt_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	input logic         chunk_valid,
	input logic         chunk_stall,
	input logic         result_valid,
	input logic         result_stall,
	input result_item_t result
);

	// A header transfer is always followed by its check cycle, during which no header is taken.
	`ASSERT_HOLDS(a_two_cycle_item,
		(chunk_valid && !chunk_stall) |=> chunk_stall,
		"header taken in check cycle")

	// A new result appears only at the end of a check cycle.
	`ASSERT_HOLDS(a_result_after_check,
		$rose(result_valid) |-> $past(chunk_stall),
		"result without check cycle")

	// A held result does not change.
	`ASSERT_HOLDS(a_result_hold,
		(result_valid && result_stall) |=> (result_valid && $stable(result)),
		"held result changed")

	// Only an accepted chunk reports a write offset.
	`ASSERT_NEVER(a_offset_on_reject,
		result_valid && result.status != ST_OK && result.write_offset != 26'd0,
		"offset on rejected chunk")

endmodule

bind chunk_reassembly_tracker_unit crt_checker u_crt_checker (.*);
